@@ rtl/core/tcd_pkg.sv @@
// Shared constants, stage interface types and lookup tables for the timestamp converter.
package tcd_pkg;

    localparam logic [30:0] DAY_DIV     = 31'd1318359375;
    localparam logic [48:0] DAY_BIAS    = 49'd140737500000000;
    localparam logic [17:0] DAY_BIAS_Q  = 18'd106752;
    localparam int          DAY_Q_BITS  = 18;
    localparam int          DAY_STAGES  = 6;
    localparam int          DAY_STEPS   = 3;

    localparam logic [20:0] SEC_DIV     = 21'd1953125;
    localparam int          SEC_Q_BITS  = 17;
    localparam int          SEC_STAGES  = 6;
    localparam int          SEC_STEPS   = 3;
    localparam logic [11:0] HOUR_DIV    = 12'd3600;
    localparam int          HOUR_Q_BITS = 5;
    localparam logic [5:0]  MIN_DIV     = 6'd60;
    localparam int          MIN_Q_BITS  = 6;

    localparam logic [21:0] JDN_MJD0    = 22'd2400001;
    localparam logic [21:0] GREG_START  = 22'd2299161;
    localparam logic [23:0] ALPHA_OFS   = 24'd7468865;
    localparam logic [17:0] ALPHA_DIV   = 18'd146097;
    localparam int          ALPHA_BITS  = 5;
    localparam logic [12:0] C_DIV       = 13'd7305;
    localparam int          C_BITS      = 13;
    localparam int          C_HI_STEPS  = 7;
    localparam logic [18:0] E_DIV       = 19'd306001;
    localparam int          E_BITS      = 4;

    localparam int          PIPE_DEPTH  = 16;

    typedef struct packed {
        logic               valid;
        logic signed [17:0] days;
        logic [46:0]        frac;
    } day_split_t;

    typedef struct packed {
        logic        valid;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [29:0] nsec;
    } clock_fields_t;

    typedef struct packed {
        logic        valid;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [8:0]  ordinal;
    } date_fields_t;

    function automatic logic [8:0] e_day_offset(input logic [3:0] e);
        logic [8:0] v;
        case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            default: v = 9'd459;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd213;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd366;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/tcd_day_div.sv @@
// Pipelined floored division of the timestamp into day number and time within the day.
module tcd_day_div
    import tcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [63:0] timestamp,
    output day_split_t  split
);

    logic        valid_reg [DAY_STAGES+1];
    logic [48:0] rem_reg   [DAY_STAGES+1];
    logic [17:0] quo_reg   [DAY_STAGES+1];
    logic [15:0] low_reg   [DAY_STAGES+1];
    logic [48:0] rem_next  [DAY_STAGES];
    logic [17:0] quo_next  [DAY_STAGES];
    logic [48:0] bias_next;

    assign bias_next = {timestamp[63], timestamp[63:16]} + DAY_BIAS;

    always_comb
    begin
        int bitpos;
        for (int s = 0; s < DAY_STAGES; s++)
        begin
            rem_next[s] = rem_reg[s];
            quo_next[s] = quo_reg[s];
            for (int j = 0; j < DAY_STEPS; j++)
            begin
                bitpos = DAY_Q_BITS - 1 - s * DAY_STEPS - j;
                if (bitpos >= 0)
                begin
                    if (rem_next[s] >= (49'(DAY_DIV) << bitpos))
                    begin
                        rem_next[s] = rem_next[s] - (49'(DAY_DIV) << bitpos);
                        quo_next[s] = {quo_next[s][16:0], 1'b1};
                    end
                    else
                    begin
                        quo_next[s] = {quo_next[s][16:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DAY_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int s = 0; s < DAY_STAGES; s++)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= bias_next;
        quo_reg[0] <= '0;
        low_reg[0] <= timestamp[15:0];
        for (int s = 0; s < DAY_STAGES; s++)
        begin
            rem_reg[s+1] <= rem_next[s];
            quo_reg[s+1] <= quo_next[s];
            low_reg[s+1] <= low_reg[s];
        end
    end

    assign split.valid = valid_reg[DAY_STAGES];
    assign split.days  = signed'(quo_reg[DAY_STAGES] - DAY_BIAS_Q);
    assign split.frac  = {rem_reg[DAY_STAGES][30:0], low_reg[DAY_STAGES]};

endmodule

@@ rtl/core/tcd_clock.sv @@
// Pipelined split of the time within a day into hour, minute, second and nanosecond.
module tcd_clock
    import tcd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  day_split_t    split,
    output clock_fields_t fields
);

    logic        valid_reg [9];
    logic [37:0] rem_reg   [SEC_STAGES+1];
    logic [16:0] quo_reg   [SEC_STAGES+1];
    logic [8:0]  low_reg   [SEC_STAGES+1];
    logic [37:0] rem_next  [SEC_STAGES];
    logic [16:0] quo_next  [SEC_STAGES];

    logic [4:0]  hour_reg, hour8_reg, hour_next;
    logic [11:0] hrem_reg, hrem_next;
    logic [29:0] nsec_reg, nsec8_reg;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;

    always_comb
    begin
        int bitpos;
        for (int s = 0; s < SEC_STAGES; s++)
        begin
            rem_next[s] = rem_reg[s];
            quo_next[s] = quo_reg[s];
            for (int j = 0; j < SEC_STEPS; j++)
            begin
                bitpos = SEC_Q_BITS - 1 - s * SEC_STEPS - j;
                if (bitpos >= 0)
                begin
                    if (rem_next[s] >= (38'(SEC_DIV) << bitpos))
                    begin
                        rem_next[s] = rem_next[s] - (38'(SEC_DIV) << bitpos);
                        quo_next[s] = {quo_next[s][15:0], 1'b1};
                    end
                    else
                    begin
                        quo_next[s] = {quo_next[s][15:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb
    begin
        logic [16:0] r;
        r = quo_reg[SEC_STAGES];
        hour_next = '0;
        for (int i = HOUR_Q_BITS - 1; i >= 0; i--)
        begin
            if (r >= (17'(HOUR_DIV) << i))
            begin
                r = r - (17'(HOUR_DIV) << i);
                hour_next = {hour_next[3:0], 1'b1};
            end
            else
            begin
                hour_next = {hour_next[3:0], 1'b0};
            end
        end
        hrem_next = r[11:0];
    end

    always_comb
    begin
        logic [11:0] r;
        r = hrem_reg;
        minute_next = '0;
        for (int i = MIN_Q_BITS - 1; i >= 0; i--)
        begin
            if (r >= (12'(MIN_DIV) << i))
            begin
                r = r - (12'(MIN_DIV) << i);
                minute_next = {minute_next[4:0], 1'b1};
            end
            else
            begin
                minute_next = {minute_next[4:0], 1'b0};
            end
        end
        second_next = r[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 9; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= split.valid;
            for (int s = 0; s < 8; s++)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= split.frac[46:9];
        quo_reg[0] <= '0;
        low_reg[0] <= split.frac[8:0];
        for (int s = 0; s < SEC_STAGES; s++)
        begin
            rem_reg[s+1] <= rem_next[s];
            quo_reg[s+1] <= quo_next[s];
            low_reg[s+1] <= low_reg[s];
        end
        hour_reg   <= hour_next;
        hrem_reg   <= hrem_next;
        nsec_reg   <= {rem_reg[SEC_STAGES][20:0], low_reg[SEC_STAGES]};
        hour8_reg  <= hour_reg;
        minute_reg <= minute_next;
        second_reg <= second_next;
        nsec8_reg  <= nsec_reg;
    end

    assign fields.valid  = valid_reg[8];
    assign fields.hour   = hour8_reg;
    assign fields.minute = minute_reg;
    assign fields.second = second_reg;
    assign fields.nsec   = nsec8_reg;

endmodule

@@ rtl/core/tcd_date.sv @@
// Pipelined conversion of a day number into calendar date, weekday and day of year.
module tcd_date
    import tcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  day_split_t   split,
    output date_fields_t fields
);

    logic        valid_reg [9];

    logic [21:0] z_reg, z1_reg;
    logic        greg_reg;
    logic [4:0]  alpha_reg, alpha_next;
    logic [2:0]  wd_reg [8];
    logic [2:0]  wd_next;
    logic [21:0] b_reg [4];
    logic [21:0] b_next;
    logic [25:0] t_reg, t3_reg, t_next, t3_next;
    logic [6:0]  chi_reg, chi_next;
    logic [12:0] c_reg [4];
    logic [12:0] c_next;
    logic [9:0]  bd_reg, bd6_reg, bd_next;
    logic [3:0]  e_reg, e_next;
    logic [11:0] year_reg, year8_reg, year_next;
    logic [3:0]  month_reg, month8_reg, month_next;
    logic [4:0]  day_reg, day8_reg, day_next;
    logic [8:0]  doy_reg, doy_next;

    always_comb
    begin
        logic [21:0] r;
        logic [21:0] zp1;
        logic [23:0] zw;
        logic [5:0]  s1;
        logic [3:0]  s2;
        logic [3:0]  s3;
        r = 22'({z_reg, 2'b00} - ALPHA_OFS);
        alpha_next = '0;
        for (int i = ALPHA_BITS - 1; i >= 0; i--)
        begin
            if (r >= (22'(ALPHA_DIV) << i))
            begin
                r = r - (22'(ALPHA_DIV) << i);
                alpha_next = {alpha_next[3:0], 1'b1};
            end
            else
            begin
                alpha_next = {alpha_next[3:0], 1'b0};
            end
        end
        zp1 = z_reg + 22'd1;
        zw  = {2'b00, zp1};
        s1  = '0;
        for (int k = 0; k < 8; k++)
        begin
            s1 = s1 + 6'(zw[3*k +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + {1'b0, s2[2:0]};
        wd_next = (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    end

    always_comb
    begin
        logic [21:0] a;
        if (greg_reg)
        begin
            a = z1_reg + 22'd1 + 22'(alpha_reg) - 22'(alpha_reg[4:2]);
        end
        else
        begin
            a = z1_reg;
        end
        b_next = a + 22'd1524;
        t_next = 26'(b_next) * 26'd20 - 26'd2442;
    end

    always_comb
    begin
        logic [25:0] r;
        r = t_reg;
        chi_next = '0;
        for (int i = C_BITS - 1; i >= C_BITS - C_HI_STEPS; i--)
        begin
            if (r >= (26'(C_DIV) << i))
            begin
                r = r - (26'(C_DIV) << i);
                chi_next = {chi_next[5:0], 1'b1};
            end
            else
            begin
                chi_next = {chi_next[5:0], 1'b0};
            end
        end
        t3_next = r;
    end

    always_comb
    begin
        logic [25:0] r;
        r = t3_reg;
        c_next = 13'(chi_reg);
        for (int i = C_BITS - C_HI_STEPS - 1; i >= 0; i--)
        begin
            if (r >= (26'(C_DIV) << i))
            begin
                r = r - (26'(C_DIV) << i);
                c_next = {c_next[11:0], 1'b1};
            end
            else
            begin
                c_next = {c_next[11:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic [23:0] prod;
        logic [21:0] diff;
        prod = 24'(c_reg[0]) * 24'd1461;
        diff = b_reg[2] - prod[23:2];
        bd_next = diff[9:0];
    end

    always_comb
    begin
        logic [23:0] r;
        r = 24'(bd_reg) * 24'd10000;
        e_next = '0;
        for (int i = E_BITS - 1; i >= 0; i--)
        begin
            if (r >= (24'(E_DIV) << i))
            begin
                r = r - (24'(E_DIV) << i);
                e_next = {e_next[2:0], 1'b1};
            end
            else
            begin
                e_next = {e_next[2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic [9:0]  dd;
        logic [12:0] yy;
        dd = bd6_reg - {1'b0, e_day_offset(e_reg)};
        day_next = dd[4:0];
        month_next = (e_reg < 4'd14) ? e_reg - 4'd1 : e_reg - 4'd13;
        yy = (month_next > 4'd2) ? c_reg[2] - 13'd4716 : c_reg[2] - 13'd4715;
        year_next = yy[11:0];
    end

    always_comb
    begin
        logic       leap;
        logic [9:0] acc;
        leap = (year_reg[1:0] == 2'b00) && (year_reg != 12'd1700) && (year_reg != 12'd1800)
               && (year_reg != 12'd1900) && (year_reg != 12'd2100);
        acc = 10'(month_start(month_reg)) + 10'(day_reg) - 10'd30;
        if (month_reg > 4'd2)
        begin
            acc = acc - (leap ? 10'd1 : 10'd2);
        end
        doy_next = acc[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 9; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= split.valid;
            for (int s = 0; s < 8; s++)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= 22'({{4{split.days[17]}}, split.days}) + JDN_MJD0;
        z1_reg    <= z_reg;
        greg_reg  <= (z_reg >= GREG_START);
        alpha_reg <= alpha_next;
        wd_reg[0] <= wd_next;
        for (int k = 0; k < 7; k++)
        begin
            wd_reg[k+1] <= wd_reg[k];
        end
        b_reg[0]  <= b_next;
        b_reg[1]  <= b_reg[0];
        b_reg[2]  <= b_reg[1];
        b_reg[3]  <= b_reg[2];
        t_reg     <= t_next;
        t3_reg    <= t3_next;
        chi_reg   <= chi_next;
        c_reg[0]  <= c_next;
        c_reg[1]  <= c_reg[0];
        c_reg[2]  <= c_reg[1];
        c_reg[3]  <= c_reg[2];
        bd_reg    <= bd_next;
        bd6_reg   <= bd_reg;
        e_reg     <= e_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        year8_reg <= year_reg;
        month8_reg <= month_reg;
        day8_reg  <= day_reg;
        doy_reg   <= doy_next;
    end

    assign fields.valid   = valid_reg[8];
    assign fields.year    = year8_reg;
    assign fields.month   = month8_reg;
    assign fields.day     = day8_reg;
    assign fields.weekday = wd_reg[7];
    assign fields.ordinal = doy_reg;

endmodule

@@ rtl/core/timestamp_to_calendar_date_time.sv @@
// Top level: converts a nanosecond timestamp into calendar date and time of day.
//
// One timestamp can be started in every clock cycle; busy never rises. Each conversion
// comes out on the result ports with done high for exactly one cycle, in start order.
// The restoring divider for the day number feeds, in parallel, the restoring divider for
// the second count with the hour and minute stages, and the calendar stages; both dividers
// retire three quotient bits per stage. The receiver cannot stall, so every result must
// be taken in the cycle it appears.
module timestamp_to_calendar_date_time
    import tcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] timestamp_ns,
    output logic               done,
    output logic [11:0]        cal_year,
    output logic [3:0]         cal_month,
    output logic [4:0]         cal_day,
    output logic [4:0]         hour_of_day,
    output logic [5:0]         minute_of_hour,
    output logic [5:0]         second_of_minute,
    output logic [29:0]        nanosecond_part,
    output logic [2:0]         weekday,
    output logic [8:0]         ordinal_day
);

    day_split_t    split;
    clock_fields_t clk_f;
    date_fields_t  date_f;

    assign busy = 1'b0;

    tcd_day_div u_day_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !busy),
        .timestamp (timestamp_ns),
        .split     (split)
    );

    tcd_clock u_clock (
        .clk    (clk),
        .rst_n  (rst_n),
        .split  (split),
        .fields (clk_f)
    );

    tcd_date u_date (
        .clk    (clk),
        .rst_n  (rst_n),
        .split  (split),
        .fields (date_f)
    );

    assign done             = date_f.valid;
    assign cal_year         = date_f.year;
    assign cal_month        = date_f.month;
    assign cal_day          = date_f.day;
    assign weekday          = date_f.weekday;
    assign ordinal_day      = date_f.ordinal;
    assign hour_of_day      = clk_f.hour;
    assign minute_of_hour   = clk_f.minute;
    assign second_of_minute = clk_f.second;
    assign nanosecond_part  = clk_f.nsec;

`ifndef SYNTH
    valid_align_a: assert property (@(posedge clk) disable iff (!rst_n)
        clk_f.valid == date_f.valid)
        else $error("Clock and date pipelines are out of step.");

    latency_a: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("Result without a matching transfer.");

    date_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cal_month >= 4'd1 && cal_month <= 4'd12 && cal_day >= 5'd1
                  && ordinal_day >= 9'd1 && ordinal_day <= 9'd366))
        else $error("Calendar field out of range.");

    time_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour_of_day < 5'd24 && minute_of_hour < 6'd60
                  && second_of_minute < 6'd60 && weekday < 3'd7))
        else $error("Time field out of range.");
`endif

endmodule

@@ dv/timestamp_to_calendar_date_time_test.sv @@
// Self-checking testbench for the timestamp to calendar date and time converter.
module timestamp_to_calendar_date_time_test;

    localparam longint NS_SEC  = 64'sd1000000000;
    localparam longint NS_DAY  = 64'sd86400000000000;
    localparam longint JDN0    = 64'sd2400001;
    localparam longint GREG_Z  = 64'sd2299161;
    localparam int     LATENCY = 16;
    localparam int     WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [29:0] nsec;
        logic [2:0]  wday;
        logic [8:0]  yday;
    } calendar_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [63:0] timestamp_ns;
    logic               done;
    logic [11:0]        cal_year;
    logic [3:0]         cal_month;
    logic [4:0]         cal_day;
    logic [4:0]         hour_of_day;
    logic [5:0]         minute_of_hour;
    logic [5:0]         second_of_minute;
    logic [29:0]        nanosecond_part;
    logic [2:0]         weekday;
    logic [8:0]         ordinal_day;

    longint    pending_stamps[$];
    calendar_t expected_dates[$];
    int        error_count;
    int        idle_cycles;
    int        send_idle_pct;

    timestamp_to_calendar_date_time uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .timestamp_ns(timestamp_ns), .done(done), .cal_year(cal_year),
        .cal_month(cal_month), .cal_day(cal_day), .hour_of_day(hour_of_day),
        .minute_of_hour(minute_of_hour), .second_of_minute(second_of_minute),
        .nanosecond_part(nanosecond_part), .weekday(weekday), .ordinal_day(ordinal_day)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit is_leap(longint y);
        if (y % 4 != 0)
            return 1'b0;
        if (y % 100 == 0 && y % 400 != 0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic calendar_t convert_stamp(longint ts);
        calendar_t r;
        longint days, frac, secs, mins, hrs, nsec;
        longint z, a, alpha, b, c, d, e, dd, mo, yr, doy;
        days = ts / NS_DAY;
        frac = ts % NS_DAY;
        if (frac < 0)
        begin
            frac += NS_DAY;
            days -= 1;
        end
        secs = frac / NS_SEC;
        nsec = frac - secs * NS_SEC;
        mins = secs / 60;
        hrs = mins / 60;
        z = days + JDN0;
        a = z;
        if (z >= GREG_Z)
        begin
            alpha = (4 * z - 7468865) / 146097;
            a = z + 1 + alpha - alpha / 4;
        end
        b = a + 1524;
        c = (20 * b - 2442) / 7305;
        d = (1461 * c) / 4;
        e = (10000 * (b - d)) / 306001;
        dd = b - d - (306001 * e) / 10000;
        mo = (e < 14) ? e - 1 : e - 13;
        yr = (mo > 2) ? c - 4716 : c - 4715;
        doy = (275 * mo) / 9 - (is_leap(yr) ? 1 : 2) * ((mo + 9) / 12) + dd - 30;
        r.year = yr[11:0];
        r.month = mo[3:0];
        r.day = dd[4:0];
        r.hour = hrs[4:0];
        r.minute = 6'(mins - hrs * 60);
        r.second = 6'(secs - mins * 60);
        r.nsec = nsec[29:0];
        r.wday = 3'((z + 1) % 7);
        r.yday = doy[8:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            expected_dates = {expected_dates, convert_stamp(timestamp_ns)};
        if (!rst_n)
            start <= 1'b0;
        else if ((start && busy) ) 
            start <= 1'b1;
        else if (pending_stamps.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            start <= 1'b1;
            timestamp_ns <= pending_stamps.pop_front();
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        calendar_t want;
        if (rst_n && done)
        begin
            if (expected_dates.size() == 0)
            begin
                $display("result transfer with no conversion outstanding");
                error_count++;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (cal_year != want.year) report_mismatch("year", cal_year, want.year);
                if (cal_month != want.month) report_mismatch("month", cal_month, want.month);
                if (cal_day != want.day) report_mismatch("day", cal_day, want.day);
                if (hour_of_day != want.hour) report_mismatch("hour", hour_of_day, want.hour);
                if (minute_of_hour != want.minute)
                    report_mismatch("minute", minute_of_hour, want.minute);
                if (second_of_minute != want.second)
                    report_mismatch("second", second_of_minute, want.second);
                if (nanosecond_part != want.nsec)
                    report_mismatch("nanosecond", nanosecond_part, want.nsec);
                if (weekday != want.wday) report_mismatch("weekday", weekday, want.wday);
                if (ordinal_day != want.yday)
                    report_mismatch("ordinal day", ordinal_day, want.yday);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timestamp_to_calendar_date_time_test: done, errors");
            $finish;
        end
    end

    function automatic longint random_stamp();
        longint v;
        int sel;
        sel = $urandom_range(3);
        v = {$urandom(), $urandom()};
        if (sel == 1)
            v = v % (NS_DAY * 64'sd100000);
        else if (sel == 2)
            v = (longint'($urandom_range(120000)) - 64'sd60000) * NS_DAY
                + longint'($urandom_range(2)) - 64'sd1;
        return v;
    endfunction

    task automatic run_phase(int pct, int count);
        send_idle_pct = pct;
        repeat (count)
            pending_stamps = {pending_stamps, random_stamp()};
        while (pending_stamps.size() > 0 || expected_dates.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        longint z_reform;
        error_count = 0;
        send_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        timestamp_ns = '0;
        z_reform = (GREG_Z - JDN0) * NS_DAY;
        pending_stamps = '{64'h8000000000000000, 64'h7fffffffffffffff, 64'sd0, -64'sd1,
            64'sd1, NS_DAY - 1, NS_DAY, -NS_DAY, -NS_DAY - 1, z_reform, z_reform - 1,
            z_reform - NS_DAY, 64'hffffffffffffffff ^ 64'h5555555555555555,
            64'h5555555555555555, 64'sd59999999999, 64'sd3599999999999,
            64'sd51544 * NS_DAY, 64'sd51603 * NS_DAY, 64'sd51604 * NS_DAY,
            64'sd51909 * NS_DAY, 64'sd55256 * NS_DAY - 1, -64'sd36 * NS_DAY};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        run_phase(0, 0);
        run_phase(0, 180);
        run_phase(67, 170);
        run_phase(33, 170);
        run_phase(0, 160);
        repeat (LATENCY + 4) @(posedge clk);
        if (error_count == 0)
            $display("timestamp_to_calendar_date_time_test: done, clean");
        else
            $display("timestamp_to_calendar_date_time_test: done, errors");
        $finish;
    end

endmodule
